### rtl/core/yaw_pitch_from_facing_vectors_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the yaw/pitch unit
// Shared concurrent-assertion shorthands; clk and arst_n must be in scope.
// ---------------------------------------------------------------------------
`ifndef YAW_PITCH_FROM_FACING_VECTORS_UNIT_DEFINES_SVH
`define YAW_PITCH_FROM_FACING_VECTORS_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define YPF_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ypf: implication check failed");

// antecedent implies consequent a fixed number of cycles later
`define YPF_ASSERT_DELAY(label, ante, dly, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error("ypf: delayed response check failed");

// expression never true out of reset
`define YPF_ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("ypf: forbidden condition seen");

`endif

### rtl/core/ypf_pkg.sv
// ---------------------------------------------------------------------------
// ypf_pkg
// Types, constants and CORDIC step functions of the yaw/pitch unit.
// ---------------------------------------------------------------------------
`default_nettype none

package ypf_pkg;

	localparam int VECTOR_WIDTH = 16;
	localparam int DW           = 36;  // datapath width, 30 fraction bits
	localparam int AW           = 36;  // angle width, 2^32 units per turn
	localparam int ALIGN_UP     = (VECTOR_WIDTH <= 30) ? 30 - VECTOR_WIDTH : 0;
	localparam int ALIGN_DN     = (VECTOR_WIDTH > 30) ? VECTOR_WIDTH - 30 : 0;

	localparam logic signed [AW-1:0] TURN_HALF    = AW'(64'sd2147483648);
	localparam logic signed [AW-1:0] TURN_QUARTER = AW'(64'sd1073741824);
	localparam logic signed [30:0]   GAIN_INV     = 31'sd652032874;
	localparam logic signed [23:0]   RAD_Q12_MUL  = 24'sd6588397;

	typedef struct packed {
		logic signed [VECTOR_WIDTH-1:0] fwd_x;
		logic signed [VECTOR_WIDTH-1:0] fwd_z;
		logic signed [VECTOR_WIDTH-1:0] up_x;
		logic signed [VECTOR_WIDTH-1:0] up_y;
		logic signed [VECTOR_WIDTH-1:0] up_z;
	} cmd_t;

	typedef struct packed {
		logic signed [15:0] yaw_angle;
		logic signed [15:0] pitch_angle;
	} result_t;

	// CORDIC working vector; a is the accumulated (vectoring) or residual (rotation) angle
	typedef struct packed {
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [AW-1:0] a;
	} cv_t;

	function automatic logic signed [AW-1:0] atan_units(int i);
		logic signed [AW-1:0] r;
		case (i)
			0:  r = AW'(64'sd536870912);
			1:  r = AW'(64'sd316933406);
			2:  r = AW'(64'sd167458907);
			3:  r = AW'(64'sd85004756);
			4:  r = AW'(64'sd42667331);
			5:  r = AW'(64'sd21354465);
			6:  r = AW'(64'sd10679838);
			7:  r = AW'(64'sd5340245);
			8:  r = AW'(64'sd2670163);
			9:  r = AW'(64'sd1335087);
			10: r = AW'(64'sd667544);
			11: r = AW'(64'sd333772);
			12: r = AW'(64'sd166886);
			13: r = AW'(64'sd83443);
			14: r = AW'(64'sd41722);
			15: r = AW'(64'sd20861);
			16: r = AW'(64'sd10430);
			17: r = AW'(64'sd5215);
			18: r = AW'(64'sd2608);
			19: r = AW'(64'sd1304);
			20: r = AW'(64'sd652);
			21: r = AW'(64'sd326);
			22: r = AW'(64'sd163);
			23: r = AW'(64'sd81);
			default: r = '0;
		endcase
		return r;
	endfunction

	// input component to 30 fraction bits, floor on right shift
	function automatic logic signed [DW-1:0] align_comp(logic signed [VECTOR_WIDTH-1:0] v);
		logic signed [DW-1:0] t;
		t = DW'(v);
		return (t <<< ALIGN_UP) >>> ALIGN_DN;
	endfunction

	function automatic cv_t vec_step(cv_t c, int i);
		cv_t r;
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;
		dx = c.y >>> i;
		dy = c.x >>> i;
		r  = c;
		if (c.y > 0) begin
			r.x = c.x + dx;
			r.y = c.y - dy;
			r.a = c.a + atan_units(i);
		end else begin
			r.x = c.x - dx;
			r.y = c.y + dy;
			r.a = c.a - atan_units(i);
		end
		return r;
	endfunction

	function automatic cv_t rot_step(cv_t c, int i);
		cv_t r;
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;
		dx = c.y >>> i;
		dy = c.x >>> i;
		r  = c;
		if (c.a >= 0) begin
			r.x = c.x - dx;
			r.y = c.y + dy;
			r.a = c.a - atan_units(i);
		end else begin
			r.x = c.x + dx;
			r.y = c.y - dy;
			r.a = c.a + atan_units(i);
		end
		return r;
	endfunction

	// vectoring pre-turn: left half-plane is turned by pi
	function automatic cv_t vec_init(logic signed [DW-1:0] x, logic signed [DW-1:0] y);
		cv_t r;
		r.x = x;
		r.y = y;
		r.a = '0;
		if (x < 0) begin
			r.x = -x;
			r.y = -y;
			r.a = (y >= 0) ? TURN_HALF : -TURN_HALF;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/core/yaw_pitch_from_facing_vectors_unit.sv
// ---------------------------------------------------------------------------
// yaw_pitch_from_facing_vectors_unit
// Yaw and pitch (Q3.12 radians) from a forward and an up vector, by CORDIC.
// ---------------------------------------------------------------------------
// Fully pipelined: a transaction is taken in every cycle (busy is tied low)
// and its result shows on result with done high for exactly one cycle.
// The receiver cannot stall, and nothing in the pipe ever waits. The
// pipeline depth is set by the three chained CORDIC sections (forward-vector
// atan2, up-vector rotation by yaw, pitch atan2), one micro-rotation per
// register stage, plus split multipliers for the gain correction and the
// radian conversion.
`default_nettype none

module yaw_pitch_from_facing_vectors_unit #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output      logic             busy,
	input  wire ypf_pkg::cmd_t    cmd,
	output      logic             done,
	output      ypf_pkg::result_t result
);

	localparam int N  = CORDIC_STEPS;
	localparam int DW = ypf_pkg::DW;
	localparam int AW = ypf_pkg::AW;

	// side data of the first atan2 section
	typedef struct packed {
		logic signed [DW-1:0] ux;
		logic signed [DW-1:0] uy;
		logic signed [DW-1:0] uz;
		logic                 uy_neg;
		logic                 zero;
	} side1_t;

	// side data of the rotation / multiply sections
	typedef struct packed {
		logic signed [AW-1:0] yaw;
		logic signed [DW-1:0] uy;
	} side2_t;

	// side data of the pitch atan2 section
	typedef struct packed {
		logic signed [AW-1:0] yaw;
		logic                 zero;
	} side3_t;

	// never stalls
	assign busy = 1'b0;

	// ---- stage 0: align inputs, pre-turn forward vector ----
	logic                 vld_fwd_s [0:N];
	ypf_pkg::cv_t         fwd_s     [0:N];
	side1_t               sd1_s     [0:N];

	logic signed [DW-1:0] fx_c, fz_c;

	always_comb begin
		fx_c = ypf_pkg::align_comp(cmd.fwd_x);
		fz_c = ypf_pkg::align_comp(cmd.fwd_z);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_fwd_s[0] <= 1'b0;
		end else begin
			vld_fwd_s[0] <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		fwd_s[0]        <= ypf_pkg::vec_init(fx_c, fz_c);
		sd1_s[0].ux     <= ypf_pkg::align_comp(cmd.up_x);
		sd1_s[0].uy     <= ypf_pkg::align_comp(cmd.up_y);
		sd1_s[0].uz     <= ypf_pkg::align_comp(cmd.up_z);
		sd1_s[0].uy_neg <= cmd.up_y[ypf_pkg::VECTOR_WIDTH-1];
		sd1_s[0].zero   <= (fx_c == '0) && (fz_c == '0);
	end

	// ---- forward atan2: one micro-rotation per stage ----
	for (genvar i = 0; i < N; i++) begin : g_fwd
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_fwd_s[i+1] <= 1'b0;
			end else begin
				vld_fwd_s[i+1] <= vld_fwd_s[i];
			end
		end
		always_ff @(posedge clk) begin
			fwd_s[i+1] <= ypf_pkg::vec_step(fwd_s[i], i);
			sd1_s[i+1] <= sd1_s[i];
		end
	end

	// ---- yaw stage ----
	logic                 vld_yaw_s1;
	logic signed [AW-1:0] yaw_s1;
	logic signed [DW-1:0] ux_s1, uy_s1, uz_s1;
	logic signed [AW-1:0] fwd_ang_c;

	assign fwd_ang_c = sd1_s[N].zero ? '0 : fwd_s[N].a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_yaw_s1 <= 1'b0;
		end else begin
			vld_yaw_s1 <= vld_fwd_s[N];
		end
	end

	always_ff @(posedge clk) begin
		// upside down: turn by a further half revolution
		yaw_s1 <= ypf_pkg::TURN_QUARTER - fwd_ang_c
			- (sd1_s[N].uy_neg ? ypf_pkg::TURN_HALF : AW'(0));
		ux_s1  <= sd1_s[N].ux;
		uy_s1  <= sd1_s[N].uy;
		uz_s1  <= sd1_s[N].uz;
	end

	// ---- rotation pre-turn: residual angle into +-pi/2 ----
	logic         vld_rot_s [0:N];
	ypf_pkg::cv_t rot_s     [0:N];
	side2_t       sd2_s     [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_rot_s[0] <= 1'b0;
		end else begin
			vld_rot_s[0] <= vld_yaw_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (yaw_s1 > ypf_pkg::TURN_QUARTER) begin
			rot_s[0].x <= -uz_s1;
			rot_s[0].y <= ux_s1;
			rot_s[0].a <= yaw_s1 - ypf_pkg::TURN_HALF;
		end else if (yaw_s1 < -ypf_pkg::TURN_QUARTER) begin
			rot_s[0].x <= -uz_s1;
			rot_s[0].y <= ux_s1;
			rot_s[0].a <= yaw_s1 + ypf_pkg::TURN_HALF;
		end else begin
			rot_s[0].x <= uz_s1;
			rot_s[0].y <= -ux_s1;
			rot_s[0].a <= yaw_s1;
		end
		sd2_s[0].yaw <= yaw_s1;
		sd2_s[0].uy  <= uy_s1;
	end

	for (genvar i = 0; i < N; i++) begin : g_rot
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_rot_s[i+1] <= 1'b0;
			end else begin
				vld_rot_s[i+1] <= vld_rot_s[i];
			end
		end
		always_ff @(posedge clk) begin
			rot_s[i+1] <= ypf_pkg::rot_step(rot_s[i], i);
			sd2_s[i+1] <= sd2_s[i];
		end
	end

	// ---- gain correction: two 18-bit partial products, then sum ----
	logic                 vld_mul_s1, vld_mul_s2;
	logic signed [49:0]   gain_lo_s1;
	logic signed [48:0]   gain_hi_s1;
	side2_t               sd2_mul_s1;
	logic signed [DW-1:0] rz_s2;
	side2_t               sd2_mul_s2;
	logic signed [18:0]   rx_lo_c;
	logic signed [17:0]   rx_hi_c;
	logic signed [67:0]   gain_sum_c;

	assign rx_lo_c    = $signed({1'b0, rot_s[N].x[17:0]});
	assign rx_hi_c    = rot_s[N].x[DW-1:18];
	assign gain_sum_c = (68'(gain_hi_s1) <<< 18) + 68'(gain_lo_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_mul_s1 <= 1'b0;
			vld_mul_s2 <= 1'b0;
		end else begin
			vld_mul_s1 <= vld_rot_s[N];
			vld_mul_s2 <= vld_mul_s1;
		end
	end

	always_ff @(posedge clk) begin
		gain_lo_s1 <= rx_lo_c * ypf_pkg::GAIN_INV;
		gain_hi_s1 <= rx_hi_c * ypf_pkg::GAIN_INV;
		sd2_mul_s1 <= sd2_s[N];
		rz_s2      <= gain_sum_c[DW+29:30];
		sd2_mul_s2 <= sd2_mul_s1;
	end

	// ---- pitch atan2 of (up_y, rotated value) ----
	logic         vld_pit_s [0:N];
	ypf_pkg::cv_t pit_s     [0:N];
	side3_t       sd3_s     [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_pit_s[0] <= 1'b0;
		end else begin
			vld_pit_s[0] <= vld_mul_s2;
		end
	end

	always_ff @(posedge clk) begin
		pit_s[0]     <= ypf_pkg::vec_init(rz_s2, sd2_mul_s2.uy);
		sd3_s[0].yaw <= sd2_mul_s2.yaw;
		sd3_s[0].zero <= (rz_s2 == '0) && (sd2_mul_s2.uy == '0);
	end

	for (genvar i = 0; i < N; i++) begin : g_pit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_pit_s[i+1] <= 1'b0;
			end else begin
				vld_pit_s[i+1] <= vld_pit_s[i];
			end
		end
		always_ff @(posedge clk) begin
			pit_s[i+1] <= ypf_pkg::vec_step(pit_s[i], i);
			sd3_s[i+1] <= sd3_s[i];
		end
	end

	// ---- final angles, conversion to Q3.12 radians ----
	logic                 vld_fin_s1, vld_cnv_s2;
	logic signed [AW-1:0] yaw_fin_s1, pitch_fin_s1;
	logic signed [42:0]   yaw_lo_s2, pitch_lo_s2;
	logic signed [41:0]   yaw_hi_s2, pitch_hi_s2;
	logic signed [61:0]   yaw_prod_c, pitch_prod_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_fin_s1 <= 1'b0;
			vld_cnv_s2 <= 1'b0;
			done       <= 1'b0;
		end else begin
			vld_fin_s1 <= vld_pit_s[N];
			vld_cnv_s2 <= vld_fin_s1;
			done       <= vld_cnv_s2;
		end
	end

	always_ff @(posedge clk) begin
		yaw_fin_s1   <= sd3_s[N].yaw;
		pitch_fin_s1 <= ypf_pkg::TURN_QUARTER - (sd3_s[N].zero ? AW'(0) : pit_s[N].a);
		yaw_lo_s2    <= $signed({1'b0, yaw_fin_s1[17:0]}) * ypf_pkg::RAD_Q12_MUL;
		yaw_hi_s2    <= $signed(yaw_fin_s1[AW-1:18]) * ypf_pkg::RAD_Q12_MUL;
		pitch_lo_s2  <= $signed({1'b0, pitch_fin_s1[17:0]}) * ypf_pkg::RAD_Q12_MUL;
		pitch_hi_s2  <= $signed(pitch_fin_s1[AW-1:18]) * ypf_pkg::RAD_Q12_MUL;
	end

	// round to nearest at bit 40
	assign yaw_prod_c   = (62'(yaw_hi_s2) <<< 18) + 62'(yaw_lo_s2) + (62'sd1 <<< 39);
	assign pitch_prod_c = (62'(pitch_hi_s2) <<< 18) + 62'(pitch_lo_s2) + (62'sd1 <<< 39);

	always_ff @(posedge clk) begin
		result.yaw_angle   <= yaw_prod_c[55:40];
		result.pitch_angle <= pitch_prod_c[55:40];
	end

endmodule

`default_nettype wire

### rtl/core/ypf_port_checker.sv
// ---------------------------------------------------------------------------
// ypf_port_checker
// Port-level timing checks of the yaw/pitch unit, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "yaw_pitch_from_facing_vectors_unit_defines.svh"

module ypf_port_checker #(
	parameter int CORDIC_STEPS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);

	// LAT spans from the start edge to the edge that samples done high, the edge after done is set
	localparam int LAT = 3 * CORDIC_STEPS + 9;

	`YPF_ASSERT_NEVER(a_never_busy, busy)
	`YPF_ASSERT_DELAY(a_start_gives_done, start && !busy, LAT, done)
	`YPF_ASSERT_IMPLY(a_done_has_start, done, $past(start && !busy, LAT))

endmodule

bind yaw_pitch_from_facing_vectors_unit ypf_port_checker #(
	.CORDIC_STEPS(CORDIC_STEPS)
) u_ypf_port_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

`default_nettype wire

### test/tb_yaw_pitch_from_facing_vectors_unit.sv
// ---------------------------------------------------------------------------
// tb_yaw_pitch_from_facing_vectors_unit
// Checks yaw and pitch from forward/up vectors against a bit-exact CORDIC model.
// ---------------------------------------------------------------------------
// A directed table (zero vectors, axis extremes, upside-down cases, the
// negative-x/zero-y branch) runs first, then random vector pairs. Each
// accepted transaction pushes the predicted angles. Each done strobe is
// compared with the oldest prediction.
`default_nettype none

module tb_yaw_pitch_from_facing_vectors_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STEPS   = 16;
	localparam int LATENCY = 3*STEPS + 9;

	localparam longint HALF_TURN    = 64'sd2147483648;
	localparam longint QUARTER_TURN = 64'sd1073741824;
	localparam longint GAIN_CORR    = 64'sd652032874;
	localparam longint TO_Q12       = 64'sd6588397;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	ypf_pkg::cmd_t     cmd;
	logic              done;
	ypf_pkg::result_t  result;

	yaw_pitch_from_facing_vectors_unit #(.CORDIC_STEPS(STEPS)) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .result(result)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// directed row: stimulus, plus an optional hand-read expectation
	typedef struct {
		ypf_pkg::cmd_t    c;
		bit               known;
		ypf_pkg::result_t r;
	} vec_row_t;

	ypf_pkg::result_t angle_queue[$];
	int               fail_count;

	// arc-tangent lookup in binary angle units
	function automatic longint arc_units(int i);
		longint tbl[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
			21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
			166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
		return tbl[i];
	endfunction

	// atan2(y, x) by CORDIC vectoring
	function automatic longint heading_units(longint y, longint x);
		longint acc;
		longint dx, dy;
		acc = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			acc = (y >= 0) ? HALF_TURN : -HALF_TURN;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; acc += arc_units(i);
			end else begin
				x -= dx; y += dy; acc -= arc_units(i);
			end
		end
		return acc;
	endfunction

	// x of (x, y) rotated by angle z, uncorrected gain
	function automatic longint turned_x(longint x, longint y, longint z);
		longint dx, dy;
		if (z > QUARTER_TURN) begin
			x = -x; y = -y; z -= HALF_TURN;
		end else if (z < -QUARTER_TURN) begin
			x = -x; y = -y; z += HALF_TURN;
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= arc_units(i);
			end else begin
				x += dx; y -= dy; z += arc_units(i);
			end
		end
		return x;
	endfunction

	function automatic logic [15:0] radians_q12(longint units);
		longint r;
		r = (units * TO_Q12 + (64'sd1 <<< 39)) >>> 40;
		return r[15:0];
	endfunction

	function automatic ypf_pkg::result_t facing_angles(ypf_pkg::cmd_t c);
		ypf_pkg::result_t r;
		longint fx, fz, ux, uy, uz, yaw, pitch, rz;
		fx = longint'(c.fwd_x) <<< 14;
		fz = longint'(c.fwd_z) <<< 14;
		ux = longint'(c.up_x) <<< 14;
		uy = longint'(c.up_y) <<< 14;
		uz = longint'(c.up_z) <<< 14;
		yaw = QUARTER_TURN - heading_units(fz, fx);
		if (c.up_y < 0)
			yaw -= HALF_TURN;
		rz = (turned_x(uz, -ux, yaw) * GAIN_CORR) >>> 30;
		pitch = QUARTER_TURN - heading_units(uy, rz);
		r.yaw_angle   = radians_q12(yaw);
		r.pitch_angle = radians_q12(pitch);
		return r;
	endfunction

	function automatic logic signed [15:0] pick_comp();
		case ($urandom_range(0, 9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sh0000;
			3: return 16'(int'($urandom_range(0, 40)) - 20);
			4, 5: return 16'(int'($urandom_range(0, 32768)) - 16384);  // unit range
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic ypf_pkg::cmd_t random_cmd();
		ypf_pkg::cmd_t c;
		c.fwd_x = pick_comp();
		c.fwd_z = pick_comp();
		c.up_x  = pick_comp();
		c.up_y  = pick_comp();
		c.up_z  = pick_comp();
		return c;
	endfunction

	// random gap before a transaction: mostly none, some short, a few long
	task automatic idle_gap();
		int n;
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4: n = $urandom_range(1, 3);
			5: n = $urandom_range(10, 40);
			default: n = 0;
		endcase
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// hold one transaction on the bus until it is taken
	task automatic issue(ypf_pkg::cmd_t c);
		idle_gap();
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		angle_queue.push_back(facing_angles(c));
	endtask

	// result side: one strobed result per cycle, no back-pressure
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (angle_queue.size() == 0) begin
				$error("unexpected result: yaw_angle %0d pitch_angle %0d",
					result.yaw_angle, result.pitch_angle);
				fail_count++;
			end else begin
				ypf_pkg::result_t want;
				want = angle_queue.pop_front();
				if (result.yaw_angle !== want.yaw_angle) begin
					$error("yaw_angle: expected %0d, actual %0d",
						want.yaw_angle, result.yaw_angle);
					fail_count++;
				end
				if (result.pitch_angle !== want.pitch_angle) begin
					$error("pitch_angle: expected %0d, actual %0d",
						want.pitch_angle, result.pitch_angle);
					fail_count++;
				end
			end
		end
	end

	initial begin
		vec_row_t rows[$];
		vec_row_t row;
		arst_n = 1'b0;
		start  = 1'b0;
		cmd    = '0;
		fail_count = 0;

		// all-zero vectors: both atan2 see (0,0), giving pi/2 -> 6434 in Q3.12
		row.c = '0; row.known = 1'b1;
		row.r.yaw_angle = 16'sd6434; row.r.pitch_angle = 16'sd6434;
		rows.push_back(row);
		row.known = 1'b0;
		row.c = '{16'sh4000, 16'sh0000, 16'sh0000, 16'sh4000, 16'sh0000}; rows.push_back(row);
		row.c = '{16'sh0000, 16'sh4000, 16'sh0000, 16'sh4000, 16'sh0000}; rows.push_back(row);
		// negative x with zero y: +pi branch
		row.c = '{16'shC000, 16'sh0000, 16'sh0000, 16'sh4000, 16'sh0000}; rows.push_back(row);
		row.c = '{16'sh0000, 16'shC000, 16'sh4000, 16'sh0000, 16'sh0000}; rows.push_back(row);
		// upside down, and up_y zero counted as upright
		row.c = '{16'sh4000, 16'sh0000, 16'sh0000, 16'shC000, 16'sh0000}; rows.push_back(row);
		row.c = '{16'sh0000, 16'sh4000, 16'sh0000, 16'sh0000, 16'sh4000}; rows.push_back(row);
		row.c = '{16'sh2D41, 16'sh2D41, 16'sh0000, 16'shFFFF, 16'sh0000}; rows.push_back(row);
		// field extremes, then near-zero and negative mid-range rows
		row.c = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}; rows.push_back(row);
		row.c = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}; rows.push_back(row);
		row.c = '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000}; rows.push_back(row);
		row.c = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF}; rows.push_back(row);
		row.c = '{16'shFFFF, 16'sh0000, 16'sh0001, 16'shFFFF, 16'sh0001}; rows.push_back(row);
		row.c = '{16'sh8000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000}; rows.push_back(row);
		row.c = '{16'sh0000, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh0000}; rows.push_back(row);
		row.c = '{16'shC000, 16'shC000, 16'shC000, 16'shC000, 16'shC000}; rows.push_back(row);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			issue(rows[i].c);
			if (rows[i].known)
				angle_queue[angle_queue.size()-1] = rows[i].r;
		end
		repeat (1600) issue(random_cmd());
		start <= 1'b0;

		while (angle_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// watchdog: 1600 items, worst-case idle gaps, plus pipeline depth
	initial begin
		#2ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
